FILE: rtl/lcgrd_pkg.sv
// shared types, constants and helper functions of the lcg random draw unit
package lcgrd_pkg;

  localparam int unsigned DRAW_W    = 32;
  localparam int unsigned OPERAND_W = 16;
  localparam int unsigned THR_W     = OPERAND_W + 1;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned LIMIT_W   = 11;
  localparam int unsigned PERC_W    = 7;

  localparam logic [DRAW_W-1:0]    LCG_MUL       = 32'd1664525;
  localparam logic [DRAW_W-1:0]    LCG_ADD       = 32'd1013904223;
  localparam logic [DRAW_W-1:0]    SEED_RESET    = 32'd1;
  localparam logic [OPERAND_W-1:0] CHANCE_SCALE  = 16'd1024;
  localparam logic [OPERAND_W-1:0] PERCENT_MAX   = 16'd100;
  localparam logic [LIMIT_W-1:0]   LIMIT_MAX     = 11'd1024;
  localparam int unsigned          TOP10_PAD     = 6;

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_CHANCE  = 2'd1,
    OP_PERCENT = 2'd2,
    OP_UNIFORM = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic fits;
    logic out_free;
  } dp_sts_t;

  // right shift that keeps the fewest top bits covering the inclusive bound
  function automatic logic [SHIFT_W-1:0] uniform_shift(input logic [OPERAND_W-1:0] bound);
    logic [SHIFT_W-1:0] msb;
    msb = '0;
    for (int i = 0; i < OPERAND_W; i++) begin
      if (bound[i]) begin
        msb = SHIFT_W'(i);
      end
    end
    return SHIFT_W'(OPERAND_W - 1) - msb;
  endfunction

  // percentage 0..100 scaled to a limit out of 1024, floor(p * 10.24)
  function automatic logic [LIMIT_W-1:0] percent_limit(input logic [PERC_W-1:0] perc);
    logic [20:0] prod;
    prod = 21'(perc) * 21'd10486;
    return prod[20:10];
  endfunction

endpackage

FILE: rtl/lcgrd_req_if.sv
// request channel interface of the lcg random draw unit
interface lcgrd_req_if import lcgrd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [OPERAND_W-1:0] operand;

  modport source (output valid, output operation, output operand, input ready);
  modport sink (input valid, input operation, input operand, output ready);
endinterface

FILE: rtl/lcgrd_res_if.sv
// result channel interface of the lcg random draw unit
interface lcgrd_res_if import lcgrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DRAW_W-1:0] drawn_value;
  logic              success;

  modport source (output valid, output drawn_value, output success, input ready);
  modport sink (input valid, input drawn_value, input success, output ready);
endinterface

FILE: rtl/lcg_random_draw_unit.sv
// Random draw unit on a 32-bit ranqd1 linear congruential generator. An item is
// first accepted and loaded, then takes one generator step per draw, since the
// single multiply-add of the state advances once a cycle while the result
// register has room: raw, chance and percent items take a single draw, a uniform
// item takes as many draws as it needs until one fits the bound (at most 2 draws
// expected for any bound). The result sits in an output register, so the next
// item is accepted while it waits; a draw only holds when that register is
// still full. A zero state is replaced by the seed register (reset 1) first.
module lcg_random_draw_unit import lcgrd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lcgrd_req_if.sink         in_req,
  lcgrd_res_if.source       out_res,
  input  logic              cfg_wr_en,
  input  logic [DRAW_W-1:0] cfg_wr_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     in_ready;

  lcgrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcgrd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_operation    (in_req.operation),
    .in_operand      (in_req.operand),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_res.valid),
    .out_ready       (out_res.ready),
    .out_drawn_value (out_res.drawn_value),
    .out_success     (out_res.success)
  );

  assign in_req.ready = in_ready;

endmodule

FILE: rtl/lcgrd_ctrl.sv
// controller state machine sequencing load, draw and result hand-off
module lcgrd_ctrl import lcgrd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } ctl_state_t;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.fits) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_enters_draw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_DRAW)
    else $error("load did not enter draw state");

  a_no_load_while_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("load and step in the same cycle");

  a_emit_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> cmd.step && sts.fits)
    else $error("result emitted without a fitting draw");
`endif

endmodule

FILE: rtl/lcgrd_dp.sv
// datapath: generator state, seed register, draw evaluation and result register
module lcgrd_dp import lcgrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [DRAW_W-1:0]    cfg_wr_data,
  input  logic [1:0]           in_operation,
  input  logic [OPERAND_W-1:0] in_operand,
  input  ctl_cmd_t             cmd,
  output dp_sts_t              sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DRAW_W-1:0]    out_drawn_value,
  output logic                 out_success
);

  logic [DRAW_W-1:0]  state_r;
  logic [DRAW_W-1:0]  state_nxt;
  logic [DRAW_W-1:0]  seed_r;
  op_t                op_r;
  logic [THR_W-1:0]   thr_r;
  logic [THR_W-1:0]   thr_nxt;
  logic [SHIFT_W-1:0] shift_r;
  logic [SHIFT_W-1:0] shift_nxt;
  logic [DRAW_W-1:0]  out_value_r;
  logic [DRAW_W-1:0]  out_value_nxt;
  logic               out_success_r;
  logic               out_success_nxt;
  logic               out_valid_r;

  logic [DRAW_W-1:0]    base;
  logic [OPERAND_W-1:0] top16;
  logic                 below;
  op_t                  in_op;
  logic [LIMIT_W-1:0]   chance_lim;
  logic [LIMIT_W-1:0]   perc_lim;
  logic [PERC_W-1:0]    perc;

  // threshold on the top 16 bits of the draw, fixed for the whole item
  always_comb begin
    in_op      = op_t'(in_operation);
    shift_nxt  = uniform_shift(in_operand);
    chance_lim = (in_operand >= CHANCE_SCALE) ? LIMIT_MAX : in_operand[LIMIT_W-1:0];
    perc       = (in_operand > PERCENT_MAX) ? PERCENT_MAX[PERC_W-1:0] : in_operand[PERC_W-1:0];
    perc_lim   = percent_limit(perc);
    case (in_op)
      OP_CHANCE:  thr_nxt = {chance_lim, {TOP10_PAD{1'b0}}};
      OP_PERCENT: thr_nxt = {perc_lim, {TOP10_PAD{1'b0}}};
      OP_UNIFORM: thr_nxt = ({1'b0, in_operand} + THR_W'(1)) << shift_nxt;
      default:    thr_nxt = '0;
    endcase
  end

  // one lcg step per cycle while the controller asserts step
  always_comb begin
    base      = (state_r == '0) ? seed_r : state_r;
    state_nxt = base * LCG_MUL + LCG_ADD;
    top16     = state_nxt[DRAW_W-1 -: OPERAND_W];
    below     = {1'b0, top16} < thr_r;
    out_value_nxt   = '0;
    out_success_nxt = 1'b0;
    case (op_r)
      OP_RAW:     out_value_nxt = state_nxt;
      OP_CHANCE:  out_success_nxt = below;
      OP_PERCENT: out_success_nxt = below;
      OP_UNIFORM: out_value_nxt = DRAW_W'(top16 >> shift_r);
      default:    out_value_nxt = '0;
    endcase
    sts.fits     = (op_r != OP_UNIFORM) || below;
    sts.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      seed_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (cmd.step) begin
        state_r <= state_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      thr_r   <= thr_nxt;
      shift_r <= shift_nxt;
    end
    if (cmd.emit) begin
      out_value_r   <= out_value_nxt;
      out_success_r <= out_success_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_value_r;
  assign out_success     = out_success_r;

`ifndef SYNTHESIS
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted item not held in result register");

  a_step_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !out_valid_r || out_ready)
    else $error("draw taken while result register is blocked");

  a_success_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_success_r |-> out_value_r == '0)
    else $error("successful chance item carries a value");
`endif

endmodule

FILE: verif/tb_lcg_random_draw_unit.sv
`timescale 1ns / 100ps
// self-checking testbench of the lcg random draw unit with its own generator predictor
module tb_lcg_random_draw_unit;
  import lcgrd_pkg::*;

  localparam logic [31:0] STEP_MUL     = 32'd1664525;
  localparam logic [31:0] STEP_ADD     = 32'd1013904223;
  localparam int unsigned TOP_SHIFT    = 22;
  localparam int unsigned CHANCE_RANGE = 1024;
  localparam int unsigned PERCENT_CAP  = 100;
  localparam int unsigned IDLE_PCT     = 21;
  localparam int          SETTLE_TICKS = 8;
  localparam int          PHASE_ITEMS  = 150;

  typedef struct packed {
    logic [DRAW_W-1:0] value;
    logic              success;
  } draw_result_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [DRAW_W-1:0] cfg_wr_data = '0;
  bit                steady      = 1'b0;
  int unsigned       error_count = 0;

  logic [DRAW_W-1:0] gen_state = '0;
  logic [DRAW_W-1:0] seed_reg  = 32'd1;
  draw_result_t      expected_draws[$];

  lcgrd_req_if req_ch ();
  lcgrd_res_if res_ch ();

  lcg_random_draw_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch.sink),
    .out_res     (res_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_RAW;
    req_ch.operand   = '0;
    res_ch.ready     = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic logic [DRAW_W-1:0] next_draw();
    if (gen_state == '0) begin
      gen_state = seed_reg;
    end
    gen_state = gen_state * STEP_MUL + STEP_ADD;
    return gen_state;
  endfunction

  function automatic draw_result_t predict_draw(op_t op, logic [OPERAND_W-1:0] operand);
    draw_result_t      r;
    int unsigned       limit;
    int unsigned       top_bits;
    logic [16:0]       span;
    logic [DRAW_W-1:0] v;
    r = '0;
    case (op)
      OP_RAW: begin
        r.value = next_draw();
      end
      OP_CHANCE: begin
        r.success = (next_draw() >> TOP_SHIFT) < operand;
      end
      OP_PERCENT: begin
        limit = (operand > PERCENT_CAP ? PERCENT_CAP : operand) * CHANCE_RANGE / PERCENT_CAP;
        r.success = (next_draw() >> TOP_SHIFT) < limit;
      end
      default: begin
        top_bits = 1;
        span     = 17'd2;
        while (span <= operand) begin
          span = span << 1;
          top_bits++;
        end
        do begin
          v = next_draw() >> (DRAW_W - top_bits);
        end while (v > operand);
        r.value = v;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    draw_result_t want;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_draws.size() == 0) begin
        $error("result with no item outstanding: drawn_value %h success %b",
               res_ch.drawn_value, res_ch.success);
        error_count++;
      end else begin
        want = expected_draws.pop_front();
        if (res_ch.drawn_value !== want.value) begin
          $error("drawn_value: expected %h, got %h", want.value, res_ch.drawn_value);
          error_count++;
        end
        if (res_ch.success !== want.success) begin
          $error("success: expected %b, got %b", want.success, res_ch.success);
          error_count++;
        end
      end
    end
  end

  task automatic send_draw(op_t op, logic [OPERAND_W-1:0] operand);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.operand   <= operand;
    do begin
      @(posedge clk);
    end while (req_ch.ready !== 1'b1);
    expected_draws.push_back(predict_draw(op, operand));
  endtask

  task automatic wait_all_drawn();
    req_ch.valid <= 1'b0;
    while (expected_draws.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_seed(logic [DRAW_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_reg = value;
  endtask

  // seed chosen so that each step lands on zero again
  task automatic test_zero_state();
    logic [DRAW_W-1:0] inv;
    logic [DRAW_W-1:0] to_zero;
    inv = STEP_MUL;
    repeat (5) inv = inv * (32'd2 - STEP_MUL * inv);
    to_zero = (32'd0 - STEP_ADD) * inv;
    write_seed(to_zero);
    send_draw(OP_RAW, 16'hFFFF);
    send_draw(OP_CHANCE, 16'd0);
    send_draw(OP_CHANCE, 16'd1);
    send_draw(OP_PERCENT, 16'd0);
    send_draw(OP_UNIFORM, 16'hFFFF);
    send_draw(OP_UNIFORM, 16'd0);
    wait_all_drawn();
    // zero seed: step taken from zero itself
    write_seed(32'd0);
    send_draw(OP_RAW, 16'd0);
  endtask

  task automatic test_chance_limits();
    send_draw(OP_CHANCE, 16'd1023);
    send_draw(OP_CHANCE, 16'd1024);
    send_draw(OP_CHANCE, 16'hFFFF);
    send_draw(OP_CHANCE, 16'd512);
  endtask

  task automatic test_percent_limits();
    send_draw(OP_PERCENT, 16'd100);
    send_draw(OP_PERCENT, 16'd101);
    send_draw(OP_PERCENT, 16'hFFFF);
    send_draw(OP_PERCENT, 16'd50);
    send_draw(OP_PERCENT, 16'd1);
  endtask

  task automatic test_uniform_bounds();
    send_draw(OP_UNIFORM, 16'd0);
    send_draw(OP_UNIFORM, 16'd1);
    send_draw(OP_UNIFORM, 16'hFFFF);
    send_draw(OP_UNIFORM, 16'h8000);
    send_draw(OP_UNIFORM, 16'd1000);
  endtask

  task automatic test_random_traffic();
    logic [DRAW_W-1:0]    seeds[5];
    op_t                  op;
    logic [OPERAND_W-1:0] operand;
    seeds = '{32'hFFFF_FFFF, $urandom(), 32'h0, $urandom(), 32'h8000_0001};
    for (int phase = 0; phase < 5; phase++) begin
      wait_all_drawn();
      write_seed(seeds[phase]);
      // one phase with no idling on either side
      steady = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 49) begin
          wait_all_drawn();
        end
        op = op_t'($urandom_range(0, 3));
        case (op)
          OP_CHANCE: begin
            operand = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 1100));
          end
          OP_PERCENT: begin
            operand = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 120));
          end
          OP_UNIFORM: begin
            operand = 16'($urandom() & ((32'd1 << $urandom_range(0, 16)) - 32'd1));
          end
          default: begin
            operand = 16'($urandom());
          end
        endcase
        send_draw(op, operand);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_state();
    test_chance_limits();
    test_percent_limits();
    test_uniform_bounds();
    test_random_traffic();
    wait_all_drawn();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
